[src/cau_pkg.sv]
// shared types, codes and helpers for the complex arithmetic unit
package cau_pkg;

    localparam int DIV_STEPS = 32;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_CONJ  = 3'd3,
        OP_RECIP = 3'd4,
        OP_DIV   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // one stage of the divider chain, with the side results riding along
    typedef struct packed {
        logic        vld;
        logic [2:0]  op;
        logic        zero;
        logic [31:0] dir_re;
        logic [31:0] dir_im;
        logic        dir_sat;
        logic        neg_r;
        logic        neg_i;
        logic        ovf_r;
        logic        ovf_i;
        logic [63:0] d;
        logic [63:0] rem_r;
        logic [63:0] rem_i;
        logic [31:0] lo_r;
        logic [31:0] lo_i;
        logic [31:0] q_r;
        logic [31:0] q_i;
    } t_div_stage;

    // sign-magnitude to 32-bit two's complement, saturated flag on top
    function automatic logic [32:0] f_clamp(input logic neg, input logic [63:0] mag);
        logic [63:0] t;
        logic [32:0] res;
        t = -mag;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) res = {1'b1, 32'h8000_0000};
            else res = {1'b0, t[31:0]};
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) res = {1'b1, 32'h7FFF_FFFF};
            else res = {1'b0, mag[31:0]};
        end
        return res;
    endfunction

endpackage

[src/complex_arithmetic_unit.sv]
// complex arithmetic unit: add, sub, mul, conj, reciprocal, divide in fixed point
//
// channel  | dir | tdata (low bit up)                 | tuser
// s_axis   | in  | a_real, a_imag, b_real, b_imag     | opcode
// m_axis   | out | real_result, imag_result           | status
//
// one request per cycle sustained while the output is not stalled; each result
// comes through the 32 restoring divider steps, one quotient bit per stage,
// after input, multiplier, adder and setup stages
// reset clears the valid bits of all stages only
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
    input  logic [2:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // real_result, imag_result
    output logic [1:0]   m_axis_tuser   // status
);
    import cau_pkg::*;

    logic en;

    // stage 1: operand selection
    logic               r1_vld;
    logic [2:0]         r1_op;
    logic signed [31:0] r1_xr, r1_xi, r1_dr, r1_di;
    logic signed [32:0] r1_yr, r1_yi, r1_er, r1_ei;
    logic signed [31:0] n_xr, n_xi, n_dr, n_di;
    logic signed [32:0] n_yr, n_yi, n_er, n_ei;

    // stage 2: products
    logic               r2_vld;
    logic [2:0]         r2_op;
    logic signed [64:0] r2_prr, r2_pii, r2_pri, r2_pir;
    logic signed [63:0] r2_sr, r2_si;
    logic signed [32:0] r2_er, r2_ei;

    // stage 3: sums
    logic               r3_vld;
    logic [2:0]         r3_op;
    logic signed [65:0] r3_vr, r3_vi;
    logic [63:0]        r3_d;
    logic signed [65:0] n_vr, n_vi;

    t_div_stage r_div [0:DIV_STEPS];
    t_div_stage n_div0;

    logic        r_out_vld;
    logic [31:0] r_out_re, r_out_im;
    logic [1:0]  r_out_st;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        logic signed [31:0] ar, ai, br, bi;
        ar = s_axis_tdata[31:0];
        ai = s_axis_tdata[63:32];
        br = s_axis_tdata[95:64];
        bi = s_axis_tdata[127:96];
        n_xr = ar;
        n_xi = ai;
        n_yr = 33'(br);
        n_yi = 33'(bi);
        n_dr = br;
        n_di = bi;
        n_er = '0;
        n_ei = '0;
        case (s_axis_tuser)
            OP_ADD: begin
                n_er = 33'(ar) + 33'(br);
                n_ei = 33'(ai) + 33'(bi);
            end
            OP_SUB: begin
                n_er = 33'(ar) - 33'(br);
                n_ei = 33'(ai) - 33'(bi);
            end
            OP_CONJ: begin
                n_er = 33'(ar);
                n_ei = -33'(ai);
            end
            OP_RECIP: begin
                // numerator is 1.0, divisor conjugated into y
                n_xr = 32'(1) <<< FRAC_BITS;
                n_xi = '0;
                n_yr = 33'(ar);
                n_yi = -33'(ai);
                n_dr = ar;
                n_di = ai;
            end
            OP_DIV: begin
                n_yr = 33'(br);
                n_yi = -33'(bi);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= s_axis_tuser;
            r1_xr  <= n_xr;
            r1_xi  <= n_xi;
            r1_yr  <= n_yr;
            r1_yi  <= n_yi;
            r1_dr  <= n_dr;
            r1_di  <= n_di;
            r1_er  <= n_er;
            r1_ei  <= n_ei;
            r2_op  <= r1_op;
            r2_prr <= 65'(r1_xr) * 65'(r1_yr);
            r2_pii <= 65'(r1_xi) * 65'(r1_yi);
            r2_pri <= 65'(r1_xr) * 65'(r1_yi);
            r2_pir <= 65'(r1_xi) * 65'(r1_yr);
            r2_sr  <= 64'(r1_dr) * 64'(r1_dr);
            r2_si  <= 64'(r1_di) * 64'(r1_di);
            r2_er  <= r1_er;
            r2_ei  <= r1_ei;
            r3_op  <= r2_op;
            r3_vr  <= n_vr;
            r3_vi  <= n_vi;
            r3_d   <= 64'(r2_sr) + 64'(r2_si);
        end
    end

    always_comb begin
        case (r2_op) inside
            OP_ADD, OP_SUB, OP_CONJ: begin
                n_vr = 66'(r2_er);
                n_vi = 66'(r2_ei);
            end
            OP_MUL, OP_RECIP, OP_DIV: begin
                n_vr = 66'(r2_prr) - 66'(r2_pii);
                n_vi = 66'(r2_pri) + 66'(r2_pir);
            end
            default: begin
                n_vr = '0;
                n_vi = '0;
            end
        endcase
    end

    // divider setup and direct results
    always_comb begin
        logic signed [65:0] ar66, ai66;
        logic [63:0] mag_r, mag_i, dm_r, dm_i, sh_r, sh_i;
        logic [32:0] c_r, c_i;
        ar66  = r3_vr[65] ? -r3_vr : r3_vr;
        ai66  = r3_vi[65] ? -r3_vi : r3_vi;
        mag_r = ar66[63:0];
        mag_i = ai66[63:0];
        dm_r  = (r3_op == OP_MUL) ? (mag_r >> FRAC_BITS) : mag_r;
        dm_i  = (r3_op == OP_MUL) ? (mag_i >> FRAC_BITS) : mag_i;
        c_r   = f_clamp(r3_vr[65], dm_r);
        c_i   = f_clamp(r3_vi[65], dm_i);
        sh_r  = mag_r << FRAC_BITS;
        sh_i  = mag_i << FRAC_BITS;
        n_div0.vld     = r3_vld;
        n_div0.op      = r3_op;
        n_div0.zero    = (r3_d == '0);
        n_div0.dir_re  = c_r[31:0];
        n_div0.dir_im  = c_i[31:0];
        n_div0.dir_sat = c_r[32] || c_i[32];
        n_div0.neg_r   = r3_vr[65];
        n_div0.neg_i   = r3_vi[65];
        n_div0.d       = r3_d;
        n_div0.rem_r   = mag_r >> (32 - FRAC_BITS);
        n_div0.rem_i   = mag_i >> (32 - FRAC_BITS);
        n_div0.ovf_r   = (mag_r >> (32 - FRAC_BITS)) >= r3_d;
        n_div0.ovf_i   = (mag_i >> (32 - FRAC_BITS)) >= r3_d;
        n_div0.lo_r    = sh_r[31:0];
        n_div0.lo_i    = sh_i[31:0];
        n_div0.q_r     = '0;
        n_div0.q_i     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div[0].vld <= 1'b0;
        end else if (en) begin
            r_div[0] <= n_div0;
        end
    end

    // restoring divider, one quotient bit per stage for real and imag
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        t_div_stage n_st;
        always_comb begin
            logic [63:0] tr, ti;
            n_st = r_div[k-1];
            tr = {r_div[k-1].rem_r[62:0], r_div[k-1].lo_r[31]};
            ti = {r_div[k-1].rem_i[62:0], r_div[k-1].lo_i[31]};
            n_st.lo_r = {r_div[k-1].lo_r[30:0], 1'b0};
            n_st.lo_i = {r_div[k-1].lo_i[30:0], 1'b0};
            if (tr >= r_div[k-1].d) begin
                n_st.rem_r = tr - r_div[k-1].d;
                n_st.q_r   = {r_div[k-1].q_r[30:0], 1'b1};
            end else begin
                n_st.rem_r = tr;
                n_st.q_r   = {r_div[k-1].q_r[30:0], 1'b0};
            end
            if (ti >= r_div[k-1].d) begin
                n_st.rem_i = ti - r_div[k-1].d;
                n_st.q_i   = {r_div[k-1].q_i[30:0], 1'b1};
            end else begin
                n_st.rem_i = ti;
                n_st.q_i   = {r_div[k-1].q_i[30:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k].vld <= 1'b0;
            end else if (en) begin
                r_div[k] <= n_st;
            end
        end
    end

    // final selection and saturation
    always_ff @(posedge i_clk) begin
        logic [32:0] c_r, c_i;
        t_div_stage  s;
        s   = r_div[DIV_STEPS];
        c_r = f_clamp(s.neg_r, s.ovf_r ? '1 : {32'd0, s.q_r});
        c_i = f_clamp(s.neg_i, s.ovf_i ? '1 : {32'd0, s.q_i});
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= s.vld;
        end
        if (en) begin
            if (s.op == OP_RECIP || s.op == OP_DIV) begin
                if (s.zero) begin
                    r_out_re <= '0;
                    r_out_im <= '0;
                    r_out_st <= ST_DIVZ;
                end else begin
                    r_out_re <= c_r[31:0];
                    r_out_im <= c_i[31:0];
                    r_out_st <= (c_r[32] || c_i[32]) ? ST_SAT : ST_OK;
                end
            end else begin
                r_out_re <= s.dir_re;
                r_out_im <= s.dir_im;
                r_out_st <= s.dir_sat ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_im, r_out_re};
    assign m_axis_tuser  = r_out_st;

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_DIVZ |-> m_axis_tdata == '0)
        else $error("zero divisor with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SAT |->
            r_out_re == 32'h7FFF_FFFF || r_out_re == 32'h8000_0000 ||
            r_out_im == 32'h7FFF_FFFF || r_out_im == 32'h8000_0000)
        else $error("saturated status without a bound value");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

[dv/tb_complex_arithmetic_unit.sv]
// self-checking testbench for the complex arithmetic unit stream interface
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY = 37;
    // opcodes the block does not define, expected to give zero with ok status
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] ONE_FX = 32'h0001_0000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } t_cx_result;

    class cau_scoreboard;
        t_cx_result pending[$];
        int errors;
        int checked;
        int op_count[8];
        int st_count[4];

        function void split(input logic signed [127:0] v, output bit neg,
                            output logic [127:0] mag);
            neg = v < 0;
            mag = neg ? -v : v;
            if (mag == 0) neg = 0;
        endfunction

        function logic [31:0] sat32(input bit neg, input logic [127:0] mag, inout bit sat);
            logic [31:0] m;
            m = mag[31:0];
            if (neg) begin
                if (mag > 128'h8000_0000) begin
                    sat = 1;
                    return MAX_NEG;
                end
                return -m;
            end
            if (mag > 128'h7FFF_FFFF) begin
                sat = 1;
                return MAX_POS;
            end
            return m;
        endfunction

        function t_cx_result compute(input logic [2:0] op, input logic signed [31:0] ar,
                                     input logic signed [31:0] ai,
                                     input logic signed [31:0] br,
                                     input logic signed [31:0] bi);
            logic signed [127:0] sar, sai, sbr, sbi, nr, ni, dr, di, d;
            logic [127:0] mr, mi;
            bit negr, negi, sat;
            t_cx_result r;
            sar = ar; sai = ai; sbr = br; sbi = bi;
            sat = 0;
            r.re = 0; r.im = 0; r.st = ST_OK;
            case (op)
                OP_ADD, OP_SUB: begin
                    split(op == OP_ADD ? sar + sbr : sar - sbr, negr, mr);
                    split(op == OP_ADD ? sai + sbi : sai - sbi, negi, mi);
                    r.re = sat32(negr, mr, sat);
                    r.im = sat32(negi, mi, sat);
                end
                OP_MUL: begin
                    split(sar * sbr - sai * sbi, negr, mr);
                    split(sar * sbi + sai * sbr, negi, mi);
                    mr = mr >> FRAC_BITS;
                    mi = mi >> FRAC_BITS;
                    if (mr == 0) negr = 0;
                    if (mi == 0) negi = 0;
                    r.re = sat32(negr, mr, sat);
                    r.im = sat32(negi, mi, sat);
                end
                OP_CONJ: begin
                    split(sar, negr, mr);
                    split(-sai, negi, mi);
                    r.re = sat32(negr, mr, sat);
                    r.im = sat32(negi, mi, sat);
                end
                OP_RECIP, OP_DIV: begin
                    if (op == OP_RECIP) begin
                        nr = 128'sd1 <<< FRAC_BITS; ni = 0; dr = sar; di = sai;
                    end else begin
                        nr = sar; ni = sai; dr = sbr; di = sbi;
                    end
                    d = dr * dr + di * di;
                    if (d == 0) begin
                        r.st = ST_DIVZ;
                    end else begin
                        split(nr * dr + ni * di, negr, mr);
                        split(ni * dr - nr * di, negi, mi);
                        mr = (mr << FRAC_BITS) / $unsigned(d);
                        mi = (mi << FRAC_BITS) / $unsigned(d);
                        if (mr == 0) negr = 0;
                        if (mi == 0) negi = 0;
                        r.re = sat32(negr, mr, sat);
                        r.im = sat32(negi, mi, sat);
                    end
                end
                default: ;
            endcase
            if (sat) r.st = ST_SAT;
            return r;
        endfunction

        function void note_request(input logic [2:0] op, input logic [127:0] data);
            pending.push_back(compute(op, data[31:0], data[63:32], data[95:64],
                                      data[127:96]));
            op_count[op]++;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(input logic [63:0] data, input logic [1:0] st);
            t_cx_result e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result re=%h im=%h st=%0d",
                                 data[31:0], data[63:32], st));
                return;
            end
            e = pending.pop_front();
            checked++;
            st_count[st]++;
            if (data[31:0] !== e.re)
                report($sformatf("result %0d real got %h want %h", checked, data[31:0], e.re));
            if (data[63:32] !== e.im)
                report($sformatf("result %0d imag got %h want %h", checked, data[63:32], e.im));
            if (st !== e.st)
                report($sformatf("result %0d status got %0d want %0d", checked, st, e.st));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // a_real, a_imag, b_real, b_imag
    logic [2:0]   s_axis_tuser;  // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;  // real_result, imag_result
    logic [1:0]   m_axis_tuser;  // status

    cau_scoreboard sb;
    bit send_burst;
    bit recv_burst;
    bit stim_done;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC_BITS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb_complex_arithmetic_unit NOT OK");
        $finish;
    end

    task send_request(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                      input logic [31:0] br, input logic [31:0] bi);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bi, br, ai, ar};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(s_axis_tuser, s_axis_tdata);
    endtask

    // operand mix: full random, values within +/-4.0, small values, the range edges and shifted random values
    function logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                           : -$urandom_range(0, 32'h0004_0000);
            3: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
            4: case ($urandom_range(0, 5))
                   0: return MAX_POS;
                   1: return MAX_NEG;
                   2: return 32'h0;
                   3: return 32'hFFFF_FFFF;
                   4: return ONE_FX;
                   default: return -ONE_FX;
               endcase
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && $urandom_range(0, 99) == 0) begin
            send_burst <= ~send_burst;
            recv_burst <= $urandom_range(0, 1);
        end
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        logic [2:0] op;
        logic [31:0] ar, ai, br, bi;
        sb = new();
        send_burst = 0;
        recv_burst = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADD;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_ADD, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
        send_request(OP_ADD, 32'h1234_5678, 32'hFFFF_0000, 32'h0000_0010, 32'h0001_0000);
        send_request(OP_SUB, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
        send_request(OP_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
        send_request(OP_MUL, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        send_request(OP_MUL, MAX_NEG, MAX_POS, MAX_NEG, MAX_NEG);
        send_request(OP_MUL, ONE_FX, -ONE_FX, 32'h0002_8000, 32'hFFFF_FFFF);
        send_request(OP_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1);
        send_request(OP_CONJ, MAX_POS, MAX_NEG, 32'hDEAD_BEEF, 32'h0);
        send_request(OP_CONJ, MAX_NEG, MAX_POS, 32'h0, 32'h0);
        send_request(OP_RECIP, 32'h0, 32'h0, MAX_POS, MAX_POS);
        send_request(OP_RECIP, ONE_FX, 32'h0, 32'h0, 32'h0);
        send_request(OP_RECIP, 32'h1, 32'h0, 32'h0, 32'h0);
        send_request(OP_RECIP, MAX_NEG, MAX_NEG, 32'h0, 32'h0);
        send_request(OP_RECIP, -ONE_FX, 32'h0000_4000, 32'h0, 32'h0);
        send_request(OP_DIV, ONE_FX, ONE_FX, 32'h0, 32'h0);
        send_request(OP_DIV, MAX_POS, MAX_NEG, 32'h1, 32'h0);
        send_request(OP_DIV, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
        send_request(OP_DIV, 32'h0003_0000, -ONE_FX, 32'h0000_8000, 32'h0002_0000);
        send_request(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h1);
        send_request(OP_SPARE6, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
        send_request(OP_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        repeat (900) begin
            op = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            // zero divisors now and then
            if ($urandom_range(0, 15) == 0) begin
                if (op == OP_RECIP) begin
                    ar = 0; ai = 0;
                end else begin
                    br = 0; bi = 0;
                end
            end
            send_request(op, ar, ai, br, bi);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("covered %0d results: add %0d sub %0d mul %0d conj %0d recip %0d div %0d spare %0d",
                 sb.checked, sb.op_count[OP_ADD], sb.op_count[OP_SUB], sb.op_count[OP_MUL],
                 sb.op_count[OP_CONJ], sb.op_count[OP_RECIP], sb.op_count[OP_DIV],
                 sb.op_count[OP_SPARE6] + sb.op_count[OP_SPARE7]);
        $display("status seen: ok %0d, divide by zero %0d, saturated %0d",
                 sb.st_count[ST_OK], sb.st_count[ST_DIVZ], sb.st_count[ST_SAT]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_complex_arithmetic_unit OK");
        end else begin
            $display("tb_complex_arithmetic_unit NOT OK");
        end
        $finish;
    end

endmodule

[complex_arithmetic_unit.f]
src/cau_pkg.sv
src/complex_arithmetic_unit.sv
dv/tb_complex_arithmetic_unit.sv
